>>> src/smac_pkg.sv
// Package with the shared types and constants of the shadow memory access checker.
package smac_pkg;

  localparam int ADDR_W      = 15;
  localparam int SIZE_W      = 13;
  localparam int MODE_W      = 2;
  localparam int KIND_W      = 3;
  localparam int CODE_W      = 5;
  localparam int NEED_W      = 4;
  localparam int BLOCK_SHIFT = 3;

  localparam logic [ADDR_W-1:0] ADDR_MAX = '1;

  // Operation codes carried by the mode field.
  localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FREE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CHECK = 2'd2;

  // Error kinds reported with each result.
  localparam logic [KIND_W-1:0] KIND_NONE    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FREED   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_UNALLOC = 3'd2;
  localparam logic [KIND_W-1:0] KIND_PARTIAL = 3'd3;
  localparam logic [KIND_W-1:0] KIND_BEYOND  = 3'd4;

  // Shadow codes, two's complement.
  localparam logic [CODE_W-1:0] CODE_UNALLOC = 5'd0;
  localparam logic [CODE_W-1:0] CODE_FULL    = 5'd8;
  localparam logic [CODE_W-1:0] CODE_FREED   = 5'h1F;

  localparam logic [NEED_W-1:0] NEED_FULL = 4'd8;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FILL,
    ST_READ,
    ST_CMP,
    ST_POST
  } state_t;

endpackage

>>> src/smac_if.sv
// Handshake interfaces for the request and result channels.
interface smac_in_if;
  import smac_pkg::*;

  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [ADDR_W-1:0] address;
  logic [SIZE_W-1:0] size;

  modport source (output valid, output mode, output address, output size, input ready);
  modport sink   (input valid, input mode, input address, input size, output ready);
endinterface

interface smac_out_if;
  import smac_pkg::*;

  logic              valid;
  logic              ready;
  logic              error;
  logic [KIND_W-1:0] error_kind;
  logic [ADDR_W-1:0] faulty_address;

  modport source (output valid, output error, output error_kind, output faulty_address,
                  input ready);
  modport sink   (input valid, input error, input error_kind, input faulty_address,
                  output ready);
endinterface

>>> src/shadow_memory_access_checker.sv
// Shadow memory access checker: one 5-bit shadow code per 8-byte block, walked one block at a time.
// After reset the block sweeps the shadow store to zero, one entry per cycle; no item is accepted
// until the sweep ends. An item is then taken in the idle state and handled alone. A mark allocated
// or mark freed item writes one shadow block per cycle through the single store write port. A check
// item reads each shadow block with a registered read and then compares it. The result sits in an
// output register, so the next item can be accepted while the previous result waits to be taken.
module shadow_memory_access_checker #(
  parameter int SHADOW_BLOCKS = 4096,
  parameter int MAX_SIZE      = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  smac_in_if.sink     in_ch,
  smac_out_if.source  out_ch
);
  import smac_pkg::*;

  localparam int MEM_AW    = $clog2(SHADOW_BLOCKS);
  localparam int REACH_W   = $clog2((1 << (ADDR_W - BLOCK_SHIFT)) + MAX_SIZE / 8 + 2);
  localparam int BLK_W     = (REACH_W > MEM_AW + 1) ? REACH_W : MEM_AW + 1;
  localparam int SZ_REQ_W  = $clog2(MAX_SIZE + 1);
  localparam int SZ_W      = (SZ_REQ_W > SIZE_W) ? SZ_REQ_W : SIZE_W;
  localparam int FA_W      = BLK_W + BLOCK_SHIFT;

  state_t             state_r, state_nxt;
  logic [BLK_W-1:0]   blk_r, blk_nxt;
  logic [SZ_W-1:0]    rem_r, rem_nxt;
  logic [NEED_W-1:0]  need_r, need_nxt;
  logic               is_free_r, is_free_nxt;
  logic [ADDR_W-1:0]  start_r, start_nxt;
  logic [KIND_W-1:0]  res_kind_r, res_kind_nxt;
  logic [ADDR_W-1:0]  res_fa_r, res_fa_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_error_r, out_error_nxt;
  logic [KIND_W-1:0]  out_kind_r, out_kind_nxt;
  logic [ADDR_W-1:0]  out_fa_r, out_fa_nxt;

  logic [CODE_W-1:0]  mem [SHADOW_BLOCKS];
  logic [CODE_W-1:0]  rd_data_r;
  logic               mem_we;
  logic               mem_re;
  logic [CODE_W-1:0]  mem_wdata;
  logic [MEM_AW-1:0]  mem_addr;

  logic               accept;
  logic               out_free;
  logic               blk_in_store;
  logic [SZ_W-1:0]    size_sat;
  logic [SZ_W:0]      head_need;
  logic [NEED_W-1:0]  rem_step;
  logic [NEED_W-1:0]  code_pos;
  logic [NEED_W-1:0]  fa_add;
  logic [FA_W-1:0]    fa_raw;
  logic [FA_W-1:0]    fa_low;
  logic [ADDR_W-1:0]  fa_sat;
  logic               probe_fail;
  logic [KIND_W-1:0]  code_kind;

  assign accept       = in_ch.valid && in_ch.ready;
  assign out_free     = !out_valid_r || out_ch.ready;
  assign blk_in_store = blk_r < BLK_W'(SHADOW_BLOCKS);
  assign mem_addr     = blk_r[MEM_AW-1:0];

  assign size_sat    = (SZ_W'(in_ch.size) > SZ_W'(MAX_SIZE)) ? SZ_W'(MAX_SIZE)
                                                              : SZ_W'(in_ch.size);
  assign head_need   = (SZ_W + 1)'(in_ch.address[BLOCK_SHIFT-1:0]) + (SZ_W + 1)'(size_sat);
  assign rem_step    = (rem_r >= SZ_W'(NEED_FULL)) ? NEED_FULL : rem_r[NEED_W-1:0];

  // A positive shadow code points past the valid bytes of its block.
  assign code_pos = (!rd_data_r[CODE_W-1] && rd_data_r != CODE_UNALLOC)
                    ? rd_data_r[NEED_W-1:0] : '0;
  assign fa_add   = (state_r == ST_CMP) ? code_pos : '0;
  assign fa_raw   = {blk_r, {BLOCK_SHIFT{1'b0}}} + FA_W'(fa_add);
  assign fa_low   = (fa_raw < FA_W'(start_r)) ? FA_W'(start_r) : fa_raw;
  assign fa_sat   = (fa_low > FA_W'(ADDR_MAX)) ? ADDR_MAX : fa_low[ADDR_W-1:0];

  assign probe_fail = $signed({1'b0, need_r}) > $signed(rd_data_r);
  assign code_kind  = (rd_data_r == CODE_FREED)   ? KIND_FREED :
                      (rd_data_r == CODE_UNALLOC) ? KIND_UNALLOC : KIND_PARTIAL;

  assign in_ch.ready           = (state_r == ST_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.error          = out_error_r;
  assign out_ch.error_kind     = out_kind_r;
  assign out_ch.faulty_address = out_fa_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (blk_r == BLK_W'(SHADOW_BLOCKS - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          if (in_ch.mode inside {MODE_ALLOC, MODE_FREE}) begin
            state_nxt = ST_FILL;
          end else if (in_ch.mode == MODE_CHECK) begin
            state_nxt = ST_READ;
          end else begin
            state_nxt = ST_POST;
          end
        end
      end
      ST_FILL: begin
        if (rem_r == '0 || !blk_in_store) state_nxt = ST_POST;
      end
      ST_READ: begin
        state_nxt = blk_in_store ? ST_CMP : ST_POST;
      end
      ST_CMP: begin
        if (probe_fail || rem_r == '0) begin
          state_nxt = ST_POST;
        end else begin
          state_nxt = ST_READ;
        end
      end
      ST_POST: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    blk_nxt       = blk_r;
    rem_nxt       = rem_r;
    need_nxt      = need_r;
    is_free_nxt   = is_free_r;
    start_nxt     = start_r;
    res_kind_nxt  = res_kind_r;
    res_fa_nxt    = res_fa_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_error_nxt = out_error_r;
    out_kind_nxt  = out_kind_r;
    out_fa_nxt    = out_fa_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_wdata     = CODE_UNALLOC;
    case (state_r)
      ST_CLEAR: begin
        mem_we  = 1'b1;
        blk_nxt = (blk_r == BLK_W'(SHADOW_BLOCKS - 1)) ? '0 : blk_r + 1'b1;
      end
      ST_IDLE: begin
        if (accept) begin
          blk_nxt      = BLK_W'(in_ch.address[ADDR_W-1:BLOCK_SHIFT]);
          start_nxt    = in_ch.address;
          is_free_nxt  = (in_ch.mode == MODE_FREE);
          rem_nxt      = size_sat;
          res_kind_nxt = KIND_NONE;
          res_fa_nxt   = '0;
          if (in_ch.mode == MODE_CHECK) begin
            // The first block needs offset plus size bytes, at most the whole block.
            if (head_need >= (SZ_W + 1)'(NEED_FULL)) begin
              need_nxt = NEED_FULL;
              rem_nxt  = SZ_W'(head_need - (SZ_W + 1)'(NEED_FULL));
            end else begin
              need_nxt = head_need[NEED_W-1:0];
              rem_nxt  = '0;
            end
          end
        end
      end
      ST_FILL: begin
        if (rem_r != '0) begin
          if (blk_in_store) begin
            mem_we    = 1'b1;
            mem_wdata = is_free_r ? CODE_FREED : CODE_W'(rem_step);
            rem_nxt   = rem_r - SZ_W'(rem_step);
            blk_nxt   = blk_r + 1'b1;
          end else begin
            res_kind_nxt = KIND_BEYOND;
            res_fa_nxt   = fa_sat;
          end
        end
      end
      ST_READ: begin
        if (blk_in_store) begin
          mem_re = 1'b1;
        end else begin
          res_kind_nxt = KIND_BEYOND;
          res_fa_nxt   = fa_sat;
        end
      end
      ST_CMP: begin
        if (probe_fail) begin
          res_kind_nxt = code_kind;
          res_fa_nxt   = fa_sat;
        end else if (rem_r != '0) begin
          need_nxt = rem_step;
          rem_nxt  = rem_r - SZ_W'(rem_step);
          blk_nxt  = blk_r + 1'b1;
        end
      end
      ST_POST: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_error_nxt = (res_kind_r != KIND_NONE);
          out_kind_nxt  = res_kind_r;
          out_fa_nxt    = res_fa_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      blk_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      blk_r       <= blk_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r      <= rem_nxt;
    need_r     <= need_nxt;
    is_free_r  <= is_free_nxt;
    start_r    <= start_nxt;
    res_kind_r <= res_kind_nxt;
    res_fa_r   <= res_fa_nxt;
    out_error_r <= out_error_nxt;
    out_kind_r <= out_kind_nxt;
    out_fa_r   <= out_fa_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
  end

  always_ff @(posedge clk) begin
    if (mem_re) rd_data_r <= mem[mem_addr];
  end

`ifndef ASSERT_OFF
  a_post_before_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_POST))
    else $error("result raised without passing through the post state");

  a_write_in_store: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> blk_in_store)
    else $error("shadow write outside the store");

  a_error_matches_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_error_r == (out_kind_r != KIND_NONE)))
    else $error("error flag disagrees with error kind");

  a_check_reads_first: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.mode == MODE_CHECK) |=> (state_r == ST_READ))
    else $error("check item did not start with a shadow read");
`endif

endmodule
